### rtl/qps_pkg.sv
// ----------------------------------------------------------------------------
// qps_pkg
// Shared constants for the quad perspective setup block.
// ----------------------------------------------------------------------------
package qps_pkg;

    localparam int QPS_COORD_WIDTH  = 16;
    localparam int QPS_WEIGHT_WIDTH = 24;
    // integer bits of a weight; the rest are fraction bits
    localparam int QPS_INT_BITS     = 8;
    // cosine limit 0.001 -> (dot * 1000)^2 > |d|^2 * |e|^2
    localparam int QPS_COS_SCALE    = 1000;
    localparam int QPS_COS_BITS     = 10;
    localparam int QPS_LANES        = 4;

endpackage

### rtl/quad_perspective_setup.sv
// ----------------------------------------------------------------------------
// quad_perspective_setup
// Per-corner projective weights and convexity check of a quad.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  input   | in_valid / in_ready        | four corners, signed Q2.14
//  output  | out_valid / out_ready      | convex_ok, diagonals_ok, 4 weights
//  config  | cfg_valid / cfg_ready      | cfg_data = perspective_mode
//
//  One transaction per cycle while the output register is not stalled;
//  the restoring divider resolves one quotient bit per stage.
//  All stages share one enable: the pipe advances unless the output
//  register holds a transaction that is not taken.
//  Reset clears the valid bits and sets perspective_mode to 1.
// ----------------------------------------------------------------------------
module quad_perspective_setup
    import qps_pkg::*;
#(
    parameter int COORD_WIDTH  = QPS_COORD_WIDTH,
    parameter int WEIGHT_WIDTH = QPS_WEIGHT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_WIDTH-1:0]  bottom_left_x,
    input  logic signed [COORD_WIDTH-1:0]  bottom_left_y,
    input  logic signed [COORD_WIDTH-1:0]  bottom_right_x,
    input  logic signed [COORD_WIDTH-1:0]  bottom_right_y,
    input  logic signed [COORD_WIDTH-1:0]  top_left_x,
    input  logic signed [COORD_WIDTH-1:0]  top_left_y,
    input  logic signed [COORD_WIDTH-1:0]  top_right_x,
    input  logic signed [COORD_WIDTH-1:0]  top_right_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           convex_ok,
    output logic                           diagonals_ok,
    output logic [WEIGHT_WIDTH-1:0]        weight_bottom_left,
    output logic [WEIGHT_WIDTH-1:0]        weight_bottom_right,
    output logic [WEIGHT_WIDTH-1:0]        weight_top_left,
    output logic [WEIGHT_WIDTH-1:0]        weight_top_right
);

    localparam int C   = COORD_WIDTH;
    localparam int W   = WEIGHT_WIDTH;
    localparam int F   = W - QPS_INT_BITS;
    localparam int N   = QPS_LANES;
    localparam int DW  = C + 1;              // corner difference
    localparam int EW  = C + 2;              // doubled midpoint offset
    localparam int XW  = 2 * DW + 1;         // det, sn, tn
    localparam int KW  = DW + EW + 1;        // convexity dot
    localparam int DDW = 2 * DW;             // |d|^2
    localparam int EEW = 2 * EW;             // |e|^2
    localparam int MW  = KW - 1 + QPS_COS_BITS;
    localparam int LW  = 2 * MW;
    localparam int RHW = DDW + EEW;
    localparam int CW  = (LW > RHW) ? LW : RHW;
    localparam int AW  = XW - 1;             // magnitude of det
    localparam int RW  = AW + W + 2;         // divider remainder

    localparam logic [W-1:0] UNIT = W'(1) << F;
    localparam logic [W-1:0] WMAX = '1;

    logic en;
    logic mode_reg;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    // ---------------- stage A: differences ----------------
    logic a_v_reg, a_m_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] cdx_reg [N], cdy_reg [N];
    logic signed [EW-1:0] cex_reg [N], cey_reg [N];

    logic signed [C-1:0] px [N], py [N], l0x [N], l0y [N], l1x [N], l1y [N];

    always_comb
    begin
        // corner, then the two neighbours forming the opposite line
        px[0] = top_left_x;     py[0] = top_left_y;
        l0x[0] = bottom_left_x; l0y[0] = bottom_left_y;
        l1x[0] = top_right_x;   l1y[0] = top_right_y;
        px[1] = top_right_x;    py[1] = top_right_y;
        l0x[1] = top_left_x;    l0y[1] = top_left_y;
        l1x[1] = bottom_right_x; l1y[1] = bottom_right_y;
        px[2] = bottom_left_x;  py[2] = bottom_left_y;
        l0x[2] = bottom_right_x; l0y[2] = bottom_right_y;
        l1x[2] = top_left_x;    l1y[2] = top_left_y;
        px[3] = bottom_right_x; py[3] = bottom_right_y;
        l0x[3] = top_right_x;   l0y[3] = top_right_y;
        l1x[3] = bottom_left_x; l1y[3] = bottom_left_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (en)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_m_reg <= mode_reg;
            d1x_reg <= DW'(top_right_x) - DW'(bottom_left_x);
            d1y_reg <= DW'(top_right_y) - DW'(bottom_left_y);
            d2x_reg <= DW'(top_left_x) - DW'(bottom_right_x);
            d2y_reg <= DW'(top_left_y) - DW'(bottom_right_y);
            ex_reg  <= DW'(bottom_left_x) - DW'(bottom_right_x);
            ey_reg  <= DW'(bottom_left_y) - DW'(bottom_right_y);
            for (int i = 0; i < N; i++)
            begin
                cdx_reg[i] <= DW'(l1x[i]) - DW'(l0x[i]);
                cdy_reg[i] <= DW'(l1y[i]) - DW'(l0y[i]);
                cex_reg[i] <= (EW'(px[i]) <<< 1) - EW'(l0x[i]) - EW'(l1x[i]);
                cey_reg[i] <= (EW'(py[i]) <<< 1) - EW'(l0y[i]) - EW'(l1y[i]);
            end
        end
    end

    // ---------------- stage B: products ----------------
    logic b_v_reg, b_m_reg;
    logic signed [2*DW-1:0] pdet0_reg, pdet1_reg, psn0_reg, psn1_reg, ptn0_reg, ptn1_reg;
    logic signed [DW+EW-1:0] pk0_reg [N], pk1_reg [N];
    logic signed [N-1:0][2*DW-1:0] pdx_reg, pdy_reg;
    logic signed [N-1:0][2*EW-1:0] pex_reg, pey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_m_reg   <= a_m_reg;
            pdet0_reg <= d1x_reg * d2y_reg;
            pdet1_reg <= d1y_reg * d2x_reg;
            psn0_reg  <= d1x_reg * ey_reg;
            psn1_reg  <= d1y_reg * ex_reg;
            ptn0_reg  <= d2x_reg * ey_reg;
            ptn1_reg  <= d2y_reg * ex_reg;
            for (int i = 0; i < N; i++)
            begin
                pk0_reg[i] <= (DW+EW)'(cdx_reg[i]) * (DW+EW)'(cey_reg[i]);
                pk1_reg[i] <= (DW+EW)'(cdy_reg[i]) * (DW+EW)'(cex_reg[i]);
                pdx_reg[i] <= cdx_reg[i] * cdx_reg[i];
                pdy_reg[i] <= cdy_reg[i] * cdy_reg[i];
                pex_reg[i] <= cex_reg[i] * cex_reg[i];
                pey_reg[i] <= cey_reg[i] * cey_reg[i];
            end
        end
    end

    // ---------------- stage C: sums ----------------
    logic c_v_reg, c_m_reg;
    logic signed [XW-1:0] det_c_reg, sn_c_reg, tn_c_reg;
    logic signed [KW-1:0] dot_reg [N];
    logic [N-1:0][DDW-1:0] dd_reg;
    logic [N-1:0][EEW-1:0] ee_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (en)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_m_reg   <= b_m_reg;
            det_c_reg <= XW'(pdet0_reg) - XW'(pdet1_reg);
            sn_c_reg  <= XW'(psn0_reg) - XW'(psn1_reg);
            tn_c_reg  <= XW'(ptn0_reg) - XW'(ptn1_reg);
            for (int i = 0; i < N; i++)
            begin
                dot_reg[i] <= KW'(pk0_reg[i]) - KW'(pk1_reg[i]);
                dd_reg[i]  <= DDW'(unsigned'(pdx_reg[i])) + DDW'(unsigned'(pdy_reg[i]));
                ee_reg[i]  <= EEW'(unsigned'(pex_reg[i])) + EEW'(unsigned'(pey_reg[i]));
            end
        end
    end

    // ---------------- stage D: sign normalize, cosine scale ----------------
    logic d_v_reg, d_m_reg, d_nz_reg;
    logic signed [XW-1:0] det_d_reg, sn_d_reg, tn_d_reg;
    logic [N-1:0] pos_d_reg;
    logic [N-1:0][MW-1:0] m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (en)
            d_v_reg <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_m_reg  <= c_m_reg;
            d_nz_reg <= (det_c_reg != '0);
            if (det_c_reg < 0)
            begin
                det_d_reg <= -det_c_reg;
                sn_d_reg  <= -sn_c_reg;
                tn_d_reg  <= -tn_c_reg;
            end
            else
            begin
                det_d_reg <= det_c_reg;
                sn_d_reg  <= sn_c_reg;
                tn_d_reg  <= tn_c_reg;
            end
            for (int i = 0; i < N; i++)
            begin
                pos_d_reg[i] <= (dot_reg[i] > 0);
                m_reg[i]     <= MW'(dot_reg[i][KW-2:0]) * MW'(QPS_COS_SCALE);
            end
        end
    end

    // ---------------- convexity multipliers ----------------
    logic [N-1:0][LW-1:0]  lhs;
    logic [N-1:0][RHW-1:0] rhs;

    for (genvar g = 0; g < N; g++)
    begin : g_cvx
        qps_mul2 #(.WA(MW), .WB(MW)) u_lhs (
            .clk (clk), .en (en), .a (m_reg[g]), .b (m_reg[g]), .p (lhs[g])
        );
        qps_mul2 #(.WA(DDW), .WB(EEW)) u_rhs (
            .clk (clk), .en (en), .a (dd_reg[g]), .b (ee_reg[g]), .p (rhs[g])
        );
    end

    // ---------------- stage E: diagonal check, denominators ----------------
    logic e_v_reg, e_m_reg, e_diag_reg;
    logic [AW-1:0] det_e_reg;
    logic [N-1:0][AW-1:0] den_e_reg;
    logic [N-1:0] pos_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else if (en)
            e_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_m_reg    <= d_m_reg;
            pos_e_reg  <= pos_d_reg;
            e_diag_reg <= d_nz_reg && (sn_d_reg > 0) && (tn_d_reg > 0)
                          && (sn_d_reg < det_d_reg) && (tn_d_reg < det_d_reg);
            det_e_reg    <= det_d_reg[AW-1:0];
            den_e_reg[0] <= AW'(det_d_reg - tn_d_reg);
            den_e_reg[1] <= AW'(det_d_reg - sn_d_reg);
            den_e_reg[2] <= sn_d_reg[AW-1:0];
            den_e_reg[3] <= tn_d_reg[AW-1:0];
        end
    end

    // ---------------- stage F: rounding dividend ----------------
    logic f_v_reg, f_m_reg, f_diag_reg;
    logic [N-1:0] pos_f_reg;
    logic [N-1:0][RHW-1:0] rhs_f_reg;
    logic [N-1:0][RW-1:0] num_f_reg, dvs_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (en)
            f_v_reg <= e_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_m_reg    <= e_m_reg;
            f_diag_reg <= e_diag_reg;
            pos_f_reg  <= pos_e_reg;
            rhs_f_reg  <= rhs;
            for (int i = 0; i < N; i++)
            begin
                // (det * 2^(F+1) + den) / (2 * den) rounds half up
                num_f_reg[i] <= (RW'(det_e_reg) << (F + 1)) + RW'(den_e_reg[i]);
                dvs_f_reg[i] <= RW'(den_e_reg[i]) << 1;
            end
        end
    end

    // ---------------- stage G: convex verdict, saturation ----------------
    logic [W:0] dv_reg, dm_reg, dcvx_reg, ddiag_reg;
    logic [W:0][N-1:0] dsat_reg;
    logic [W:0][N-1:0][RW-1:0] drem_reg, ddvs_reg;
    logic [W:0][N-1:0][W-1:0] dq_reg;

    logic cvx_g;

    always_comb
    begin
        cvx_g = 1'b1;
        for (int i = 0; i < N; i++)
            cvx_g = cvx_g && pos_f_reg[i] && (CW'(lhs[i]) > CW'(rhs_f_reg[i]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else if (en)
            dv_reg <= {dv_reg[W-1:0], f_v_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg[0]    <= f_m_reg;
            dcvx_reg[0]  <= cvx_g;
            ddiag_reg[0] <= f_diag_reg;
            for (int i = 0; i < N; i++)
            begin
                dsat_reg[0][i] <= (num_f_reg[i] >= (dvs_f_reg[i] << W));
                drem_reg[0][i] <= num_f_reg[i];
                ddvs_reg[0][i] <= dvs_f_reg[i];
                dq_reg[0][i]   <= '0;
            end
        end
    end

    // ---------------- restoring divider, one bit per stage ----------------
    for (genvar k = 0; k < W; k++)
    begin : g_div
        localparam int B = W - 1 - k;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dm_reg[k+1]    <= dm_reg[k];
                dcvx_reg[k+1]  <= dcvx_reg[k];
                ddiag_reg[k+1] <= ddiag_reg[k];
                dsat_reg[k+1]  <= dsat_reg[k];
                ddvs_reg[k+1]  <= ddvs_reg[k];
                for (int i = 0; i < N; i++)
                begin
                    if (drem_reg[k][i] >= (ddvs_reg[k][i] << B))
                    begin
                        drem_reg[k+1][i]  <= drem_reg[k][i] - (ddvs_reg[k][i] << B);
                        dq_reg[k+1][i]    <= dq_reg[k][i] | (W'(1) << B);
                    end
                    else
                    begin
                        drem_reg[k+1][i]  <= drem_reg[k][i];
                        dq_reg[k+1][i]    <= dq_reg[k][i];
                    end
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic out_v_reg, cvx_o_reg, diag_o_reg;
    logic [N-1:0][W-1:0] w_o_reg;
    logic [N-1:0][W-1:0] w_next;
    logic cvx_next, diag_next;

    always_comb
    begin
        cvx_next  = !dm_reg[W] || dcvx_reg[W];
        diag_next = dm_reg[W] && ddiag_reg[W];
        for (int i = 0; i < N; i++)
        begin
            if (!diag_next)
                w_next[i] = UNIT;
            else if (dsat_reg[W][i])
                w_next[i] = WMAX;
            else
                w_next[i] = dq_reg[W][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cvx_o_reg  <= cvx_next;
            diag_o_reg <= diag_next;
            w_o_reg    <= w_next;
        end
    end

    assign out_valid           = out_v_reg;
    assign convex_ok           = cvx_o_reg;
    assign diagonals_ok        = diag_o_reg;
    assign weight_bottom_left  = w_o_reg[0];
    assign weight_bottom_right = w_o_reg[1];
    assign weight_top_left     = w_o_reg[2];
    assign weight_top_right    = w_o_reg[3];

endmodule

### rtl/qps_mul2.sv
// ----------------------------------------------------------------------------
// qps_mul2
// Two-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module qps_mul2 #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [WA-1:0]        a,
    input  logic [WB-1:0]        b,
    output logic [WA+WB-1:0]     p
);

    localparam int LA = WA / 2;
    localparam int HA = WA - LA;
    localparam int LB = WB / 2;
    localparam int HB = WB - LB;
    localparam int PW = WA + WB;

    logic [HA+HB-1:0] hh_reg;
    logic [HA+LB-1:0] hl_reg;
    logic [LA+HB-1:0] lh_reg;
    logic [LA+LB-1:0] ll_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    always_comb
    begin
        p_next = (PW'(hh_reg) << (LA + LB)) + (PW'(hl_reg) << LA)
               + (PW'(lh_reg) << LB) + PW'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= a[WA-1:LA] * b[WB-1:LB];
            hl_reg <= a[WA-1:LA] * b[LB-1:0];
            lh_reg <= a[LA-1:0] * b[WB-1:LB];
            ll_reg <= a[LA-1:0] * b[LB-1:0];
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

### rtl/qps_checker.sv
// ----------------------------------------------------------------------------
// qps_checker
// Port-level checks of the quad perspective setup block.
// ----------------------------------------------------------------------------
module qps_checker
    import qps_pkg::*;
#(
    parameter int WEIGHT_WIDTH = QPS_WEIGHT_WIDTH
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    diagonals_ok,
    input logic [WEIGHT_WIDTH-1:0] weight_bottom_left,
    input logic [WEIGHT_WIDTH-1:0] weight_bottom_right,
    input logic [WEIGHT_WIDTH-1:0] weight_top_left,
    input logic [WEIGHT_WIDTH-1:0] weight_top_right
);

    localparam logic [WEIGHT_WIDTH-1:0] UNIT =
        WEIGHT_WIDTH'(1) << (WEIGHT_WIDTH - QPS_INT_BITS);

    // stalled output transaction holds out_valid, weight_top_left and diagonals_ok
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight_top_left)
                                    && $stable(diagonals_ok))
        else $error("output transaction changed while stalled");

    // an empty output register never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // no crossing means unit weights
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !diagonals_ok |-> weight_bottom_left == UNIT
            && weight_bottom_right == UNIT && weight_top_left == UNIT
            && weight_top_right == UNIT)
        else $error("unit weights expected");

    // a valid crossing gives weights of at least one
    a_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && diagonals_ok |-> weight_bottom_left >= UNIT
            && weight_bottom_right >= UNIT && weight_top_left >= UNIT
            && weight_top_right >= UNIT)
        else $error("weight below one");

endmodule

bind quad_perspective_setup qps_checker #(.WEIGHT_WIDTH(WEIGHT_WIDTH)) u_qps_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_ready            (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .diagonals_ok        (diagonals_ok),
    .weight_bottom_left  (weight_bottom_left),
    .weight_bottom_right (weight_bottom_right),
    .weight_top_left     (weight_top_left),
    .weight_top_right    (weight_top_right)
);
